// ===== design/dpm_pkg.sv =====
// Package for the disparity false-color map: shared types and constants.
// Used by the divider cells, the color lanes and the top level. No dependencies.
package dpm_pkg;

  // Configuration register indexes (word address bits [3:2]).
  typedef enum logic [1:0] {
    REG_MAX_DISP    = 2'd0,
    REG_SATURATION  = 2'd1,
    REG_VALUE_LEVEL = 2'd2
  } reg_idx_t;

  // Hue sectors of the HSV color wheel.
  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

  // Sector width of the hue scale.
  localparam logic [7:0] HUE_SECTOR = 8'd60;

  // One in Q16 (sector fraction) and in Q24 (term scale).
  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [25:0] ONE_Q24 = 26'h1000000;

  // Reciprocal of 15 scaled for f = r * 16384 / 15, then corrected once.
  localparam logic [12:0] RECIP_15 = 13'd4369;
  localparam logic [4:0]  FIFTEEN  = 5'd15;

  // Data handed from one divider cell to the next.
  typedef struct packed {
    logic [15:0] rem;    // partial remainder, scaled by two per cell
    logic [7:0]  m;      // divisor (max_disp)
    logic [7:0]  q;      // quotient bits so far
    logic        blk;    // force black output
  } div_data_t;

  // Stage enables of the color lanes.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } lane_en_t;

endpackage

// ===== design/disparity_pseudocolor_map.sv =====
// Top level of the disparity false-color map: registers, divider chain, sectors, lanes.
// Depends on dpm_pkg, dpm_div_cell and dpm_color_lane.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | input     | in_valid / in_ready   | in_disparity[7:0]
//  out     | output    | out_valid / out_ready | out_blue, out_green, out_red
//  cfg     | input     | psel/penable/pwrite   | paddr[3:0], pwdata, prdata
//
// One pixel per clock is accepted unless a stalled output holds the pipeline;
// its result shows on out_valid after fourteen register stages: an input stage,
// eight divider cells (one quotient bit each), two sector stages and three
// stages in each color lane.
// Reset (synchronous, rst_n low) empties the pipeline and loads the register
// defaults. A stalled output holds only the stages behind it that are full;
// empty stages keep taking new pixels.
module disparity_pseudocolor_map (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_disparity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dpm_pkg::*;

  localparam int NCELL = 8;

  // Configuration registers.
  logic [7:0] max_disp_r;
  logic [8:0] sat_r;
  logic [8:0] val_r;
  logic       cfg_wr;

  // Input stage.
  logic       v_in_r;
  div_data_t  in_data_r, in_data_nxt;
  logic [7:0] dm;
  logic       en_in;

  // Divider chain.
  logic       cv   [NCELL];
  div_data_t  cd   [NCELL];
  logic       cen  [NCELL];

  // Sector stages.
  logic        v_sa_r, v_sb_r, en_sa, en_sb;
  sector_t     hi_r, hi_nxt;
  logic [5:0]  r_r, r_nxt;
  logic        blk_a_r, blk_b_r;
  logic [7:0]  hue;
  logic [17:0] q0_prod;
  logic [15:0] q0;
  logic [19:0] rem15;
  logic [15:0] f;
  logic [16:0] kp, kq, kt;
  logic [16:0] kb_r, kg_r, kr_r, kb_nxt, kg_nxt, kr_nxt;

  // Lane stage control.
  logic [2:0] lv_r;
  lane_en_t   len;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Register writes; writes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_disp_r <= 8'd255;
      sat_r      <= 9'd256;
      val_r      <= 9'd256;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MAX_DISP:    max_disp_r <= pwdata[7:0];
        REG_SATURATION:  sat_r      <= pwdata[8:0];
        REG_VALUE_LEVEL: val_r      <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (paddr[3:2])
      REG_MAX_DISP:    prdata = {24'b0, max_disp_r};
      REG_SATURATION:  prdata = {23'b0, sat_r};
      REG_VALUE_LEVEL: prdata = {23'b0, val_r};
      default:         prdata = 32'b0;
    endcase
  end

  // Ready chain from the output back to the input: a stage moves when it is
  // empty or the stage after it moves.
  assign len.s3 = !lv_r[2] || out_ready;
  assign len.s2 = !lv_r[1] || len.s3;
  assign len.s1 = !lv_r[0] || len.s2;
  assign en_sb  = !v_sb_r  || len.s1;
  assign en_sa  = !v_sa_r  || en_sb;

  always_comb begin
    cen[NCELL-1] = !cv[NCELL-1] || en_sa;
    for (int i = NCELL - 2; i >= 0; i--) begin
      cen[i] = !cv[i] || cen[i+1];
    end
  end

  assign en_in    = !v_in_r || cen[0];
  assign in_ready = en_in;

  // Input stage: dividend (max - d) * 240, zero when d exceeds max.
  assign dm = max_disp_r - in_disparity;
  always_comb begin
    in_data_nxt.m   = max_disp_r;
    in_data_nxt.q   = 8'd0;
    in_data_nxt.blk = (max_disp_r == 8'd0);
    if (in_disparity > max_disp_r) begin
      in_data_nxt.rem = 16'd0;
    end else begin
      in_data_nxt.rem = {dm, 8'b0} - {4'b0, dm, 4'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_in_r <= 1'b0;
    end else if (en_in) begin
      v_in_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_in) begin
      in_data_r <= in_data_nxt;
    end
  end

  // Divider chain, most significant quotient bit first.
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    if (g == 0) begin : g_first
      dpm_div_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (cen[g]),
        .in_valid  (v_in_r),
        .in_data   (in_data_r),
        .out_valid (cv[g]),
        .out_data  (cd[g])
      );
    end else begin : g_next
      dpm_div_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (cen[g]),
        .in_valid  (cv[g-1]),
        .in_data   (cd[g-1]),
        .out_valid (cv[g]),
        .out_data  (cd[g])
      );
    end
  end

  // Sector stage A: hue sector and the hue within the sector.
  assign hue = cd[NCELL-1].q;
  always_comb begin
    if (hue >= 8'(4 * HUE_SECTOR)) begin
      hi_nxt = SEC_4;
      r_nxt  = 6'(hue - 8'(4 * HUE_SECTOR));
    end else if (hue >= 8'(3 * HUE_SECTOR)) begin
      hi_nxt = SEC_3;
      r_nxt  = 6'(hue - 8'(3 * HUE_SECTOR));
    end else if (hue >= 8'(2 * HUE_SECTOR)) begin
      hi_nxt = SEC_2;
      r_nxt  = 6'(hue - 8'(2 * HUE_SECTOR));
    end else if (hue >= HUE_SECTOR) begin
      hi_nxt = SEC_1;
      r_nxt  = 6'(hue - HUE_SECTOR);
    end else begin
      hi_nxt = SEC_0;
      r_nxt  = hue[5:0];
    end
  end

  // Sector stage B: fraction f = r * 2^16 / 60 by reciprocal with one
  // correction, then the per-channel multiplier of S.
  assign q0_prod = {12'b0, r_r} * {5'b0, RECIP_15};
  assign q0      = q0_prod[17:2];
  assign rem15   = {r_r, 14'b0} - (20'(q0) * 20'(FIFTEEN));
  assign f       = (rem15 >= 20'(FIFTEEN)) ? (q0 + 16'd1) : q0;

  // The value term uses multiplier zero, p uses one, q uses f, t uses 1 - f.
  assign kp = ONE_Q16;
  assign kq = {1'b0, f};
  assign kt = ONE_Q16 - {1'b0, f};

  always_comb begin
    unique case (hi_r)
      SEC_0: begin kb_nxt = kp;    kg_nxt = kt;    kr_nxt = 17'd0; end
      SEC_1: begin kb_nxt = kp;    kg_nxt = 17'd0; kr_nxt = kq;    end
      SEC_2: begin kb_nxt = kt;    kg_nxt = 17'd0; kr_nxt = kp;    end
      SEC_3: begin kb_nxt = 17'd0; kg_nxt = kq;    kr_nxt = kp;    end
      SEC_4: begin kb_nxt = 17'd0; kg_nxt = kp;    kr_nxt = kt;    end
      default: begin kb_nxt = kq;  kg_nxt = kp;    kr_nxt = 17'd0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_sa_r <= 1'b0;
      v_sb_r <= 1'b0;
      lv_r   <= 3'b0;
    end else begin
      if (en_sa)  v_sa_r  <= cv[NCELL-1];
      if (en_sb)  v_sb_r  <= v_sa_r;
      if (len.s1) lv_r[0] <= v_sb_r;
      if (len.s2) lv_r[1] <= lv_r[0];
      if (len.s3) lv_r[2] <= lv_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en_sa) begin
      hi_r    <= hi_nxt;
      r_r     <= r_nxt;
      blk_a_r <= cd[NCELL-1].blk;
    end
    if (en_sb) begin
      kb_r    <= kb_nxt;
      kg_r    <= kg_nxt;
      kr_r    <= kr_nxt;
      blk_b_r <= blk_a_r;
    end
  end

  // Color lanes.
  dpm_color_lane u_blue (
    .clk (clk), .en (len), .k (kb_r), .blk (blk_b_r),
    .sat (sat_r), .val (val_r), .chan_byte (out_blue)
  );
  dpm_color_lane u_green (
    .clk (clk), .en (len), .k (kg_r), .blk (blk_b_r),
    .sat (sat_r), .val (val_r), .chan_byte (out_green)
  );
  dpm_color_lane u_red (
    .clk (clk), .en (len), .k (kr_r), .blk (blk_b_r),
    .sat (sat_r), .val (val_r), .chan_byte (out_red)
  );

  assign out_valid = lv_r[2];

  // An accepted transaction always lands in the input stage.
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v_in_r)
    else $error("accepted transaction did not reach the input stage");

  // A live divisor never yields a hue past the blue end.
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cv[NCELL-1] && !cd[NCELL-1].blk) |-> (cd[NCELL-1].q <= 8'd240))
    else $error("hue quotient out of range");

  // With a live divisor the last sector never occurs.
  a_no_sector5: assert property (@(posedge clk) disable iff (!rst_n)
    (v_sa_r && !blk_a_r) |-> (hi_r != SEC_5))
    else $error("unreachable hue sector seen");

  // The hue within a sector stays below the sector width.
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    (v_sa_r && !blk_a_r) |-> (r_r < HUE_SECTOR[5:0] || r_r == 6'd0))
    else $error("hue within sector out of range");

endmodule

// ===== design/dpm_div_cell.sv =====
// One cell of the hue divider chain: yields one quotient bit per cell.
// Depends on dpm_pkg for the cell data struct.
module dpm_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  dpm_pkg::div_data_t in_data,
  output logic              out_valid,
  output dpm_pkg::div_data_t out_data
);
  import dpm_pkg::*;

  logic        valid_r;
  div_data_t   data_r;
  div_data_t   data_nxt;
  logic [15:0] sub;
  logic        ge;
  logic [15:0] diff;

  // Compare the remainder with the divisor aligned to the top quotient bit.
  assign sub  = {1'b0, in_data.m, 7'b0};
  assign ge   = (in_data.rem >= sub);
  assign diff = ge ? (in_data.rem - sub) : in_data.rem;

  // The remainder after a subtract stays below the aligned divisor, so one shift fits.
  always_comb begin
    data_nxt     = in_data;
    data_nxt.rem = {diff[14:0], 1'b0};
    data_nxt.q   = {in_data.q[6:0], ge};
  end

  // Valid is control state; the data needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== design/dpm_color_lane.sv =====
// One color channel: term k*S, scaling by V, clamp and conversion to a byte.
// Depends on dpm_pkg for the enable struct and the Q24 constant.
module dpm_color_lane (
  input  logic              clk,
  input  dpm_pkg::lane_en_t en,
  input  logic [16:0]       k,
  input  logic              blk,
  input  logic [8:0]        sat,
  input  logic [8:0]        val,
  output logic [7:0]        chan_byte
);
  import dpm_pkg::*;

  logic [25:0]        prod_r, prod_nxt;
  logic               blk1_r, blk2_r;
  logic signed [26:0] w;
  logic signed [36:0] x_r, x_nxt;
  logic [39:0]        y;
  logic [7:0]         byte_r, byte_nxt;

  // First stage: product of the sector multiplier and the saturation.
  assign prod_nxt = {9'b0, k} * {17'b0, sat};

  // Second stage: term W = 1 - k*S in Q24, then scaled by V.
  assign w     = $signed({1'b0, ONE_Q24}) - $signed({1'b0, prod_r});
  assign x_nxt = 37'(w) * 37'($signed({1'b0, val}));

  // Third stage: zero when black, else clamp to [0, 1.0] in Q32 and take (x * 255) >> 32.
  assign y = {x_r[31:0], 8'b0} - {8'b0, x_r[31:0]};

  always_comb begin
    if (blk2_r) begin
      byte_nxt = 8'd0;
    end else if (x_r[36]) begin
      byte_nxt = 8'd0;
    end else if (|x_r[35:32]) begin
      byte_nxt = 8'hFF;
    end else begin
      byte_nxt = y[39:32];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod_r <= prod_nxt;
      blk1_r <= blk;
    end
    if (en.s2) begin
      x_r    <= x_nxt;
      blk2_r <= blk1_r;
    end
    if (en.s3) begin
      byte_r <= byte_nxt;
    end
  end

  assign chan_byte = byte_r;

endmodule
